// ===== design/upd_pkg.sv =====
// Shared types, character codes and helpers for the URL path decode and check block.
package upd_pkg;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_DOT     = 8'h2E;

   typedef struct packed {
      logic [7:0] uri_byte;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [7:0] decoded_byte;
      logic       byte_valid;
      logic       request_done;
      logic       verdict;
   } rsp_type;

   typedef enum logic [2:0] {
      PH_NORMAL = 3'b001,
      PH_HIGH   = 3'b010,
      PH_LOW    = 3'b100
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [3:0] high_nibble;
      logic       prev_was_dot;
      logic       seen_any_byte;
      logic       bad_seen;
   } dec_state_type;

   localparam dec_state_type DEC_STATE_RESET = '{
      phase:         PH_NORMAL,
      high_nibble:   4'h0,
      prev_was_dot:  1'b0,
      seen_any_byte: 1'b0,
      bad_seen:      1'b0
   };

endpackage

// ===== design/upd_step.sv =====
// Next-state and result logic for one URI byte: escape decoding and path checks.
module upd_step
   import upd_pkg::*;
(
   input  dec_state_type state_ff,
   input  req_type       req,
   output dec_state_type state_in,
   output rsp_type       rsp
);

   logic       hex_ok;
   logic [3:0] hex_val;
   logic [7:0] dec;
   logic       valid;
   dec_state_type st;

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'h0;
      if (req.uri_byte >= 8'h30 && req.uri_byte <= 8'h39) begin
         hex_val = req.uri_byte[3:0];
      end else if ((req.uri_byte >= 8'h41 && req.uri_byte <= 8'h46) ||
                   (req.uri_byte >= 8'h61 && req.uri_byte <= 8'h66)) begin
         // 'A'..'F' and 'a'..'f' share their low three bits: 1..6 maps to 10..15.
         hex_val = 4'd9 + {1'b0, req.uri_byte[2:0]};
      end else begin
         hex_ok = 1'b0;
      end
   end

   always_comb begin
      st    = state_ff;
      dec   = 8'h00;
      valid = 1'b0;

      unique case (state_ff.phase)
         PH_HIGH: begin
            if (hex_ok) begin
               st.high_nibble = hex_val;
               st.phase       = PH_LOW;
            end else begin
               st.bad_seen = 1'b1;
               st.phase    = PH_NORMAL;
            end
         end
         PH_LOW: begin
            if (hex_ok) begin
               dec   = {state_ff.high_nibble, hex_val};
               valid = 1'b1;
            end else begin
               st.bad_seen = 1'b1;
            end
            st.phase = PH_NORMAL;
         end
         default: begin
            st.phase = PH_NORMAL;
            if (req.uri_byte == CH_PERCENT) begin
               st.phase = PH_HIGH;
            end else if (req.uri_byte == CH_PLUS) begin
               dec   = CH_SPACE;
               valid = 1'b1;
            end else begin
               dec   = req.uri_byte;
               valid = 1'b1;
            end
         end
      endcase

      if (valid) begin
         if (!state_ff.seen_any_byte && dec != CH_SLASH) begin
            st.bad_seen = 1'b1;
         end
         if (dec == CH_DOT && state_ff.prev_was_dot) begin
            st.bad_seen = 1'b1;
         end
         st.prev_was_dot  = (dec == CH_DOT);
         st.seen_any_byte = 1'b1;
      end

      rsp.decoded_byte = dec;
      rsp.byte_valid   = valid;
      rsp.request_done = req.is_last;
      rsp.verdict      = 1'b0;
      state_in         = st;

      // The last byte closes the request: report and start clean for the next URI.
      if (req.is_last) begin
         rsp.verdict = st.bad_seen || !st.seen_any_byte || (st.phase != PH_NORMAL);
         state_in    = DEC_STATE_RESET;
      end
   end

endmodule

// ===== design/url_path_decode_check.sv =====
// Top level of the URL path decode and check block: handshakes, state and result registers.
//
// Usage:
//   The request channel (req_valid, req_ready, req_data) carries the URI one raw byte
//   per item, with is_last set on the final byte. Every item yields exactly one item
//   on the result channel (rsp_valid, rsp_ready, rsp_data): the decoded byte when
//   byte_valid is set, request_done on the result of the last byte, and there the
//   verdict (0 ok path, 1 bad request).
//   rsp_valid is registered and rises in the cycle after acceptance. Throughput is
//   one byte per cycle; the decode state is updated in the accepting cycle, so the next
//   byte needs nothing more than the result register being free.
//   The result register is the only buffer: req_ready is high whenever it is empty or
//   its item is taken in the same cycle. A stalled receiver holds the result and stops
//   intake after one item.
//   Reset empties the result register and returns the decoder to the start of a URI;
//   the decoder also returns there by itself after each last byte.
module url_path_decode_check
   import upd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   dec_state_type state_ff, state_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff;
   logic          accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   upd_step u_step (
      .state_ff (state_ff),
      .req      (req_data),
      .state_in (state_in),
      .rsp      (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= DEC_STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== design/upd_checker.sv =====
// Port-level checker for the URL path decode and check block, bound to the top level.
module upd_checker
   import upd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A result waiting for the receiver stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed or dropped while stalled");

   // Each accepted byte shows up as a result in the next cycle, done flag mirroring is_last.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid && (rsp_data.request_done == $past(req_data.is_last)))
      else $error("accepted item did not produce its result");

   // A verdict of bad request appears only on the closing result.
   a_verdict_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.verdict |-> rsp_data.request_done)
      else $error("verdict set on a result that does not close the request");

   // Results without a decoded byte carry a zero byte.
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.byte_valid |-> rsp_data.decoded_byte == 8'h00)
      else $error("decoded byte nonzero without byte_valid");

endmodule

bind url_path_decode_check upd_checker u_upd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
